/* rtl/kcq_pkg.sv */
// Shared types and constants of the k-means color quantizer.
`default_nettype none
package kcq_pkg;
	localparam int DEF_MAX_PIXELS   = 4096;
	localparam int DEF_MAX_CLUSTERS = 8;

	// Distance width: the largest color distance is floor(sqrt(3 * 255 * 255)) = 441.
	localparam int DIST_W   = 9;
	// Width of a sum of three squared 8-bit differences.
	localparam int SQ_W     = 18;
	localparam int DIV_STEPS  = 8;
	localparam int SQRT_STEPS = 9;
	localparam logic [SQ_W-1:0] SQRT_TOP_BIT = 18'h10000;

	localparam logic [23:0] EMPTY_CENTRE = 24'h0000FF;
	localparam logic [3:0]  RST_NUM_CLUSTERS = 4'd2;
	localparam logic [7:0]  RST_MAX_ITER     = 8'd64;

	localparam logic [1:0] REG_NUM_CLUSTERS = 2'd0;
	localparam logic [1:0] REG_COLOR_MODE   = 2'd1;
	localparam logic [1:0] REG_MAX_ITER     = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_PIXEL  = 2'd0,
		CMD_SET_CENTRE  = 2'd1,
		CMD_READ_PIXEL  = 2'd2,
		CMD_READ_CENTRE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DONE   = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_CENTRE = 2'd2
	} kind_t;

	typedef enum logic {
		OP_DIV  = 1'b0,
		OP_SQRT = 1'b1
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_rsp_t;
endpackage
`default_nettype wire

/* rtl/kcq_in_if.sv */
// Input channel of the quantizer: commands with pixel or centre data.
`default_nettype none
interface kcq_in_if;
	logic              valid;
	logic              ready;
	kcq_pkg::cmd_t     command;
	logic [11:0]       item_index;
	logic [7:0]        chan0;
	logic [7:0]        chan1;
	logic [7:0]        chan2;
	logic              last_pixel;

	modport source(output valid, command, item_index, chan0, chan1, chan2, last_pixel,
		input ready);
	modport sink(input valid, command, item_index, chan0, chan1, chan2, last_pixel,
		output ready);
endinterface
`default_nettype wire

/* rtl/kcq_out_if.sv */
// Output channel of the quantizer: readouts and clustering status.
`default_nettype none
interface kcq_out_if;
	logic              valid;
	logic              ready;
	kcq_pkg::kind_t    result_kind;
	logic [2:0]        cluster_label;
	logic [7:0]        out_c0;
	logic [7:0]        out_c1;
	logic [7:0]        out_c2;
	logic [7:0]        pass_count;
	logic              converged;

	modport source(output valid, result_kind, cluster_label, out_c0, out_c1, out_c2,
		pass_count, converged, input ready);
	modport sink(input valid, result_kind, cluster_label, out_c0, out_c1, out_c2,
		pass_count, converged, output ready);
endinterface
`default_nettype wire

/* rtl/kcq_iter_unit.sv */
// Shared iterative unit: restoring divide (8-bit quotient) or integer square root.
`default_nettype none
module kcq_iter_unit #(
	parameter int CW = 13,
	parameter int NW = 21
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kcq_pkg::iter_req_t          req,
	input  wire logic [NW-1:0]               num,
	input  wire logic [CW-1:0]               den,
	output kcq_pkg::iter_rsp_t               rsp,
	output logic [kcq_pkg::DIST_W-1:0]       result
);
	logic                busy_q;
	logic                done_q;
	kcq_pkg::iter_op_t   op_q;
	logic [NW-1:0]       a_q;
	logic [NW-1:0]       b_q;
	logic [NW-1:0]       r_q;
	logic [3:0]          n_q;
	logic [NW-1:0]       trial;
	logic                fits;
	logic [3:0]          last_step;

	// The divide subtracts the shifted divisor; the root subtracts root plus bit.
	assign trial     = (op_q == kcq_pkg::OP_DIV) ? b_q : r_q + b_q;
	assign fits      = a_q >= trial;
	assign last_step = (op_q == kcq_pkg::OP_DIV) ? 4'(kcq_pkg::DIV_STEPS - 1)
		: 4'(kcq_pkg::SQRT_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				a_q    <= num;
				r_q    <= '0;
				n_q    <= '0;
				b_q    <= (req.op == kcq_pkg::OP_DIV) ? NW'({den, 7'b0})
					: NW'(kcq_pkg::SQRT_TOP_BIT);
			end else if (busy_q) begin
				if (fits) begin
					a_q <= a_q - trial;
					r_q <= (op_q == kcq_pkg::OP_DIV) ? {r_q[NW-2:0], 1'b1}
						: (r_q >> 1) + b_q;
				end else begin
					r_q <= (op_q == kcq_pkg::OP_DIV) ? {r_q[NW-2:0], 1'b0} : r_q >> 1;
				end
				b_q <= (op_q == kcq_pkg::OP_DIV) ? b_q >> 1 : b_q >> 2;
				n_q <= n_q + 4'd1;
				if (n_q == last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign result   = r_q[kcq_pkg::DIST_W-1:0];
endmodule
`default_nettype wire

/* rtl/kmeans_color_quantizer_unit.sv */
// Top level: command decode, frame memories and the clustering sequencer.
// Loads and centre writes complete on acceptance; a centre read answers through the
// result stage, a pixel read after a label memory read, then centre lookup.
// Clustering runs after the last pixel; each pass measures every pixel against each centre,
// by one difference in gray mode or by three squares and a 9-step root in color mode, then
// sets each centre: an empty cluster gets the empty value, else an 8-step divide per channel.
// Reset clears control, configuration and centres; pixel and label memories are not cleared.
`default_nettype none
module kmeans_color_quantizer_unit #(
	parameter int MAX_PIXELS   = kcq_pkg::DEF_MAX_PIXELS,
	parameter int MAX_CLUSTERS = kcq_pkg::DEF_MAX_CLUSTERS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	kcq_in_if.sink          in_ch,
	kcq_out_if.source       out_ch,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int SW = CW + 8;
	localparam int NW = (SW > kcq_pkg::SQ_W) ? SW : kcq_pkg::SQ_W;
	localparam int LW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int KW = $clog2(MAX_CLUSTERS + 1);
	localparam int DW = kcq_pkg::DIST_W;

	typedef enum logic [3:0] {
		S_IDLE, S_LRD, S_LOUT, S_PUT, S_PASS, S_PRD, S_DIST, S_SQ, S_SQW,
		S_ACC, S_UPD, S_DIVS, S_DIVW, S_UWR, S_PEND
	} state_t;

	state_t               state_q;
	logic [3:0]           ncl_q;
	logic                 cmode_q;
	logic [7:0]           maxit_q;
	logic [CW-1:0]        pcnt_q;
	logic [CW-1:0]        p_q;
	logic [KW-1:0]        j_q;
	logic [1:0]           ch_q;
	logic [LW-1:0]        best_q;
	logic [DW-1:0]        bestd_q;
	logic [kcq_pkg::SQ_W-1:0] acc_q;
	logic [7:0]           nv_q [3];
	logic                 changed_q;
	logic [7:0]           pass_q;
	logic [AW-1:0]        ra_q;
	logic [23:0]          cen_q [MAX_CLUSTERS];
	logic [SW-1:0]        sum_q [MAX_CLUSTERS][3];
	logic [CW-1:0]        cnt_q [MAX_CLUSTERS];

	kcq_pkg::kind_t       res_kind_q;
	logic [2:0]           res_lab_q;
	logic [23:0]          res_c_q;
	logic [7:0]           res_pass_q;
	logic                 res_conv_q;

	logic                 ov_q;
	kcq_pkg::kind_t       o_kind_q;
	logic [2:0]           o_lab_q;
	logic [23:0]          o_c_q;
	logic [7:0]           o_pass_q;
	logic                 o_conv_q;

	logic [23:0]          pix_mem [MAX_PIXELS];
	logic [LW-1:0]        lab_mem [MAX_PIXELS];
	logic [23:0]          pix_rd_q;
	logic [LW-1:0]        lab_rd_q;

	logic                 in_fire;
	logic                 pix_ok;
	logic                 cen_ok;
	logic                 pix_we;
	logic                 lab_we;
	logic [23:0]          in_val;
	logic [KW-1:0]        k_eff;
	logic [7:0]           lim;
	logic [7:0]           pass_nx;
	logic                 klast;
	logic                 plast;
	logic [LW-1:0]        cen_ra;
	logic [23:0]          cen_rd;
	logic [23:0]          cen_view;
	logic [LW-1:0]        sidx;
	logic [7:0]           pc;
	logic [7:0]           cc;
	logic [7:0]           diff;
	logic [15:0]          sq;
	logic [kcq_pkg::SQ_W-1:0] acc_nx;
	logic [DW-1:0]        dcand;
	logic                 better;
	logic [23:0]          nv;
	logic [23:0]          nv_view;
	kcq_pkg::iter_req_t   iter_req;
	kcq_pkg::iter_rsp_t   iter_rsp;
	logic [NW-1:0]        iter_num;
	logic [DW-1:0]        iter_res;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign pix_ok      = 32'(in_ch.item_index) < 32'(MAX_PIXELS);
	assign cen_ok      = 32'(in_ch.item_index) < 32'(MAX_CLUSTERS);
	assign in_val      = {in_ch.chan2, in_ch.chan1, in_ch.chan0};
	assign pix_we      = in_fire && (in_ch.command == kcq_pkg::CMD_LOAD_PIXEL) && pix_ok;
	assign lab_we      = (state_q == S_ACC);

	always_comb begin
		if (ncl_q == 4'd0) begin
			k_eff = KW'(1);
		end else if (32'(ncl_q) > 32'(MAX_CLUSTERS)) begin
			k_eff = KW'(MAX_CLUSTERS);
		end else begin
			k_eff = KW'(ncl_q);
		end
	end

	assign lim     = (maxit_q == 8'd0) ? 8'd1 : maxit_q;
	assign pass_nx = pass_q + 8'd1;
	assign klast   = (j_q == k_eff - KW'(1));
	assign plast   = (CW'(p_q + CW'(1)) == pcnt_q);

	// One read port on the centre registers, shared by readouts and the passes.
	always_comb begin
		unique case (state_q)
			S_IDLE:  cen_ra = in_ch.item_index[LW-1:0];
			S_LOUT:  cen_ra = lab_rd_q;
			default: cen_ra = j_q[LW-1:0];
		endcase
	end
	assign cen_rd   = cen_q[cen_ra];
	assign cen_view = cmode_q ? cen_rd : {16'd0, cen_rd[7:0]};
	assign sidx     = (state_q == S_ACC) ? best_q : j_q[LW-1:0];

	always_comb begin
		case (ch_q)
			2'd1:    begin pc = pix_rd_q[15:8];  cc = cen_rd[15:8];  end
			2'd2:    begin pc = pix_rd_q[23:16]; cc = cen_rd[23:16]; end
			default: begin pc = pix_rd_q[7:0];   cc = cen_rd[7:0];   end
		endcase
	end
	assign diff   = (pc > cc) ? pc - cc : cc - pc;
	assign sq     = diff * diff;
	assign acc_nx = ((ch_q == 2'd0) ? '0 : acc_q) + kcq_pkg::SQ_W'(sq);
	assign dcand  = (state_q == S_SQW) ? iter_res : DW'(diff);
	assign better = (j_q == '0) || (dcand < bestd_q);

	assign nv = (cnt_q[sidx] == '0) ? kcq_pkg::EMPTY_CENTRE
		: cmode_q ? {nv_q[2], nv_q[1], nv_q[0]} : {16'd0, nv_q[0]};
	assign nv_view = cmode_q ? nv : {16'd0, nv[7:0]};

	assign iter_req.start = (state_q == S_SQ) || (state_q == S_DIVS);
	assign iter_req.op    = (state_q == S_SQ) ? kcq_pkg::OP_SQRT : kcq_pkg::OP_DIV;
	assign iter_num       = (state_q == S_SQ) ? NW'(acc_q) : NW'(sum_q[sidx][ch_q]);

	kcq_iter_unit #(
		.CW(CW),
		.NW(NW)
	) u_iter (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (iter_req),
		.num   (iter_num),
		.den   (cnt_q[sidx]),
		.rsp   (iter_rsp),
		.result(iter_res)
	);

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[AW'(in_ch.item_index)] <= in_val;
		end
		pix_rd_q <= pix_mem[p_q[AW-1:0]];
		if (lab_we) begin
			lab_mem[p_q[AW-1:0]] <= best_q;
		end
		lab_rd_q <= lab_mem[ra_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ncl_q     <= kcq_pkg::RST_NUM_CLUSTERS;
			cmode_q   <= 1'b0;
			maxit_q   <= kcq_pkg::RST_MAX_ITER;
			pcnt_q    <= '0;
			pass_q    <= '0;
			changed_q <= 1'b0;
			ov_q      <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				cen_q[i] <= '0;
				cnt_q[i] <= '0;
				for (int c = 0; c < 3; c++) begin
					sum_q[i][c] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kcq_pkg::REG_NUM_CLUSTERS: ncl_q   <= cfg_data[3:0];
					kcq_pkg::REG_COLOR_MODE:   cmode_q <= cfg_data[0];
					kcq_pkg::REG_MAX_ITER:     maxit_q <= cfg_data;
					default: ;
				endcase
			end
			// While a result waits to be loaded, the load below decides the valid flag.
			if (ov_q && out_ch.ready && state_q != S_PUT) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (in_ch.command)
							kcq_pkg::CMD_LOAD_PIXEL: begin
								if (pix_ok && in_ch.last_pixel) begin
									pcnt_q  <= CW'(32'(in_ch.item_index) + 1);
									pass_q  <= '0;
									state_q <= S_PASS;
								end
							end
							kcq_pkg::CMD_SET_CENTRE: begin
								if (cen_ok) begin
									cen_q[in_ch.item_index[LW-1:0]] <= in_val;
								end
							end
							kcq_pkg::CMD_READ_PIXEL: begin
								if (pix_ok) begin
									ra_q    <= AW'(in_ch.item_index);
									state_q <= S_LRD;
								end
							end
							kcq_pkg::CMD_READ_CENTRE: begin
								if (cen_ok) begin
									res_kind_q <= kcq_pkg::KIND_CENTRE;
									res_lab_q  <= 3'(cen_ra);
									res_c_q    <= cen_view;
									res_pass_q <= '0;
									res_conv_q <= 1'b0;
									state_q    <= S_PUT;
								end
							end
							default: ;
						endcase
					end
				end
				S_LRD: begin
					state_q <= S_LOUT;
				end
				S_LOUT: begin
					res_kind_q <= kcq_pkg::KIND_PIXEL;
					res_lab_q  <= 3'(lab_rd_q);
					res_c_q    <= cen_view;
					res_pass_q <= '0;
					res_conv_q <= 1'b0;
					state_q    <= S_PUT;
				end
				S_PUT: begin
					if (!ov_q || out_ch.ready) begin
						ov_q     <= 1'b1;
						o_kind_q <= res_kind_q;
						o_lab_q  <= res_lab_q;
						o_c_q    <= res_c_q;
						o_pass_q <= res_pass_q;
						o_conv_q <= res_conv_q;
						state_q  <= S_IDLE;
					end
				end
				S_PASS: begin
					for (int i = 0; i < MAX_CLUSTERS; i++) begin
						cnt_q[i] <= '0;
						for (int c = 0; c < 3; c++) begin
							sum_q[i][c] <= '0;
						end
					end
					p_q       <= '0;
					changed_q <= 1'b0;
					state_q   <= S_PRD;
				end
				S_PRD: begin
					// The pixel word arrives from the memory at the end of this cycle.
					j_q     <= '0;
					ch_q    <= 2'd0;
					state_q <= S_DIST;
				end
				S_DIST: begin
					if (cmode_q) begin
						acc_q <= acc_nx;
						if (ch_q == 2'd2) begin
							state_q <= S_SQ;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end else begin
						if (better) begin
							best_q  <= j_q[LW-1:0];
							bestd_q <= dcand;
						end
						if (klast) begin
							state_q <= S_ACC;
						end else begin
							j_q  <= j_q + KW'(1);
							ch_q <= 2'd0;
						end
					end
				end
				S_SQ: begin
					state_q <= S_SQW;
				end
				S_SQW: begin
					if (iter_rsp.done) begin
						if (better) begin
							best_q  <= j_q[LW-1:0];
							bestd_q <= dcand;
						end
						ch_q <= 2'd0;
						if (klast) begin
							state_q <= S_ACC;
						end else begin
							j_q     <= j_q + KW'(1);
							state_q <= S_DIST;
						end
					end
				end
				S_ACC: begin
					cnt_q[sidx]    <= cnt_q[sidx] + CW'(1);
					sum_q[sidx][0] <= sum_q[sidx][0] + SW'(pix_rd_q[7:0]);
					sum_q[sidx][1] <= sum_q[sidx][1] + SW'(pix_rd_q[15:8]);
					sum_q[sidx][2] <= sum_q[sidx][2] + SW'(pix_rd_q[23:16]);
					if (plast) begin
						j_q     <= '0;
						ch_q    <= 2'd0;
						state_q <= S_UPD;
					end else begin
						p_q     <= p_q + CW'(1);
						state_q <= S_PRD;
					end
				end
				S_UPD: begin
					ch_q    <= 2'd0;
					state_q <= (cnt_q[sidx] == '0) ? S_UWR : S_DIVS;
				end
				S_DIVS: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (iter_rsp.done) begin
						nv_q[ch_q] <= iter_res[7:0];
						if (cmode_q && ch_q != 2'd2) begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_DIVS;
						end else begin
							state_q <= S_UWR;
						end
					end
				end
				S_UWR: begin
					if (nv_view != cen_view) begin
						changed_q <= 1'b1;
					end
					cen_q[sidx] <= nv;
					if (klast) begin
						state_q <= S_PEND;
					end else begin
						j_q     <= j_q + KW'(1);
						state_q <= S_UPD;
					end
				end
				S_PEND: begin
					pass_q <= pass_nx;
					if (!changed_q || pass_nx >= lim) begin
						res_kind_q <= kcq_pkg::KIND_DONE;
						res_lab_q  <= '0;
						res_c_q    <= '0;
						res_pass_q <= pass_nx;
						res_conv_q <= !changed_q;
						state_q    <= S_PUT;
					end else begin
						state_q <= S_PASS;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.result_kind   = o_kind_q;
	assign out_ch.cluster_label = o_lab_q;
	assign out_ch.out_c0        = o_c_q[7:0];
	assign out_ch.out_c1        = o_c_q[15:8];
	assign out_ch.out_c2        = o_c_q[23:16];
	assign out_ch.pass_count    = o_pass_q;
	assign out_ch.converged     = o_conv_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		iter_req.start |-> !iter_rsp.busy)
		else $error("shared unit started while busy");

	a_done_has_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.result_kind == kcq_pkg::KIND_DONE) |-> out_ch.pass_count != 8'd0)
		else $error("clustering finished with no pass counted");

	a_centre_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIST || state_q == S_UPD) |-> (j_q < k_eff))
		else $error("centre number beyond clusters in use");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT && ov_q && !out_ch.ready) |=> (state_q == S_PUT))
		else $error("result dropped while output register full");
endmodule
`default_nettype wire

/* sim/tb_kmeans_color_quantizer_unit.sv */
// Self-checking testbench of the k-means color quantizer: directed table, then random frames.
`timescale 1ns / 100ps
module tb_kmeans_color_quantizer_unit;

	localparam int NPIX     = 4096;
	localparam int NCTR     = 8;
	localparam int LIMIT    = 100000000;
	localparam int HOLD_LEN = 400;
	localparam int SETTLE   = 40;

	typedef struct {
		kcq_pkg::kind_t kind;
		logic [2:0] label;
		logic [7:0] c0, c1, c2;
		logic [7:0] passes;
		logic       conv;
	} quant_res_t;

	typedef struct {
		kcq_pkg::cmd_t cmd;
		logic [11:0] idx;
		logic [7:0]  c0, c1, c2;
		logic        last;
		bit          typed;
		quant_res_t  res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	kcq_in_if  in_ch();
	kcq_out_if out_ch();

	kmeans_color_quantizer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Model state of the quantizer.
	logic [23:0] pix_mem [NPIX];
	logic [2:0]  lab_mem [NPIX];
	logic [23:0] centres [NCTR];
	int unsigned cfg_k, cfg_color, cfg_iter;
	int          labelled_upto;

	quant_res_t  expected_q [$];
	stim_row_t   dir_tab [$];
	int          err_cnt;
	int          transfers;
	int          cycles;
	bit          idle_on;
	bit          hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic report(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		err_cnt++;
	endtask

	function automatic int unsigned root_floor(input int unsigned x);
		int unsigned r;
		int unsigned t;
		r = 0;
		for (int b = 8; b >= 0; b--) begin
			t = r | (1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic int unsigned color_dist(input logic [23:0] p, input logic [23:0] c);
		int unsigned s;
		int a, b;
		s = 0;
		if (cfg_color == 0) begin
			a = p[7:0];
			b = c[7:0];
			return (a > b) ? a - b : b - a;
		end
		for (int i = 0; i < 3; i++) begin
			a = p[8*i +: 8];
			b = c[8*i +: 8];
			s += (a - b) * (a - b);
		end
		return root_floor(s);
	endfunction

	function automatic logic [23:0] centre_seen(input logic [23:0] v);
		return (cfg_color != 0) ? v : {16'h0, v[7:0]};
	endfunction

	// Lloyd passes over pixels 0..n-1 until the centres settle or the pass limit.
	function automatic void cluster_frame(input int n, output logic [7:0] passes,
		output logic conv);
		int k, lim, best;
		int unsigned bd, d;
		int unsigned sums [NCTR][3];
		int unsigned cnt [NCTR];
		logic [23:0] nv;
		bit moved;
		k = (cfg_k == 0) ? 1 : ((cfg_k > NCTR) ? NCTR : cfg_k);
		lim = (cfg_iter == 0) ? 1 : cfg_iter;
		passes = 8'd0;
		while (1) begin
			for (int j = 0; j < NCTR; j++) begin
				cnt[j] = 0;
				for (int c = 0; c < 3; c++)
					sums[j][c] = 0;
			end
			for (int p = 0; p < n; p++) begin
				best = 0;
				bd = color_dist(pix_mem[p], centres[0]);
				for (int j = 1; j < k; j++) begin
					d = color_dist(pix_mem[p], centres[j]);
					if (d < bd) begin
						bd = d;
						best = j;
					end
				end
				lab_mem[p] = best[2:0];
				cnt[best]++;
				for (int c = 0; c < 3; c++)
					sums[best][c] += pix_mem[p][8*c +: 8];
			end
			moved = 0;
			for (int j = 0; j < k; j++) begin
				if (cnt[j] == 0)
					nv = 24'h0000FF;
				else if (cfg_color == 0)
					nv = {16'h0, 8'(sums[j][0] / cnt[j])};
				else
					nv = {8'(sums[j][2] / cnt[j]), 8'(sums[j][1] / cnt[j]),
						8'(sums[j][0] / cnt[j])};
				if (centre_seen(nv) != centre_seen(centres[j]))
					moved = 1;
				centres[j] = nv;
			end
			passes++;
			if (!moved) begin
				conv = 1'b1;
				return;
			end
			if (passes >= lim) begin
				conv = 1'b0;
				return;
			end
		end
	endfunction

	// Applies one accepted command to the model; returns 1 when it yields a result.
	function automatic bit quantizer_step(input stim_row_t it, output quant_res_t r);
		logic [23:0] v;
		logic [2:0] lab;
		v = {it.c2, it.c1, it.c0};
		r = '{kcq_pkg::KIND_DONE, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
		case (it.cmd)
			kcq_pkg::CMD_LOAD_PIXEL: begin
				pix_mem[it.idx] = v;
				if (!it.last)
					return 0;
				cluster_frame(int'(it.idx) + 1, r.passes, r.conv);
				if (int'(it.idx) + 1 > labelled_upto)
					labelled_upto = int'(it.idx) + 1;
				return 1;
			end
			kcq_pkg::CMD_SET_CENTRE: begin
				if (it.idx < NCTR)
					centres[it.idx] = v;
				return 0;
			end
			kcq_pkg::CMD_READ_PIXEL: begin
				lab = lab_mem[it.idx];
				r.kind = kcq_pkg::KIND_PIXEL;
			end
			default: begin
				if (it.idx >= NCTR)
					return 0;
				lab = it.idx[2:0];
				r.kind = kcq_pkg::KIND_CENTRE;
			end
		endcase
		v = centre_seen(centres[lab]);
		r.label = lab;
		{r.c2, r.c1, r.c0} = v;
		return 1;
	endfunction

	task automatic check_result();
		quant_res_t e;
		if (expected_q.size() == 0) begin
			report("result with nothing expected");
			return;
		end
		e = expected_q.pop_front();
		if (out_ch.result_kind !== e.kind)
			report($sformatf("kind %0d, expected %0d", out_ch.result_kind, e.kind));
		if (out_ch.cluster_label !== e.label)
			report($sformatf("label %0d, expected %0d", out_ch.cluster_label, e.label));
		if (out_ch.out_c0 !== e.c0)
			report($sformatf("c0 %0d, expected %0d", out_ch.out_c0, e.c0));
		if (out_ch.out_c1 !== e.c1)
			report($sformatf("c1 %0d, expected %0d", out_ch.out_c1, e.c1));
		if (out_ch.out_c2 !== e.c2)
			report($sformatf("c2 %0d, expected %0d", out_ch.out_c2, e.c2));
		if (out_ch.pass_count !== e.passes)
			report($sformatf("passes %0d, expected %0d", out_ch.pass_count, e.passes));
		if (out_ch.converged !== e.conv)
			report($sformatf("converged %0b, expected %0b", out_ch.converged, e.conv));
	endtask

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall, hold;
		stall = 0;
		hold = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				check_result();
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 0;
				hold = HOLD_LEN;
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 17) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one command, waits for its transfer and updates the model.
	task automatic send_cmd(input stim_row_t it);
		quant_res_t r;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.command    <= it.cmd;
		in_ch.item_index <= it.idx;
		in_ch.chan0      <= it.c0;
		in_ch.chan1      <= it.c1;
		in_ch.chan2      <= it.c2;
		in_ch.last_pixel <= it.last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		transfers++;
		if (quantizer_step(it, r))
			expected_q.insert(expected_q.size(), it.typed ? it.res : r);
	endtask

	function automatic void add_row(input stim_row_t s);
		dir_tab.insert(dir_tab.size(), s);
	endfunction

	function automatic stim_row_t mk(input kcq_pkg::cmd_t cmd, input int idx, input int c0,
		input int c1, input int c2, input bit last);
		stim_row_t s;
		s.cmd = cmd;
		s.idx = idx[11:0];
		s.c0 = c0[7:0];
		s.c1 = c1[7:0];
		s.c2 = c2[7:0];
		s.last = last;
		s.typed = 0;
		s.res = '{kcq_pkg::KIND_DONE, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0};
		return s;
	endfunction

	function automatic stim_row_t mkx(input stim_row_t s, input kcq_pkg::kind_t kind,
		input int label, input int c0, input int passes, input bit conv);
		s.typed = 1;
		s.res = '{kind, label[2:0], c0[7:0], 8'd0, 8'd0, passes[7:0], conv};
		return s;
	endfunction

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input int k, input int color, input int iter);
		cfg_we <= 1'b1;
		cfg_index <= kcq_pkg::REG_NUM_CLUSTERS;
		cfg_data <= k[7:0];
		@(posedge clk);
		cfg_index <= kcq_pkg::REG_COLOR_MODE;
		cfg_data <= color[7:0];
		@(posedge clk);
		cfg_index <= kcq_pkg::REG_MAX_ITER;
		cfg_data <= iter[7:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_k = k & 15;
		cfg_color = color & 1;
		cfg_iter = iter & 255;
	endtask

	function automatic logic [7:0] near(input int base);
		int v;
		v = base + $urandom_range(0, 40) - 20;
		return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
	endfunction

	// One frame: optional centre seeding, a full load ending in the last pixel with centre reads mixed in, then reads.
	task automatic random_frame();
		int n;
		int hub [4];
		int h;
		stim_row_t s;
		for (int i = 0; i < 4; i++)
			hub[i] = $urandom_range(0, 255);
		for (int j = 0; j < NCTR; j++)
			if ($urandom_range(0, 3) != 0)
				send_cmd(mk(kcq_pkg::CMD_SET_CENTRE, j, $urandom, $urandom, $urandom,
					$urandom_range(0, 7) == 0));
		if ($urandom_range(0, 3) == 0)
			send_cmd(mk(kcq_pkg::CMD_SET_CENTRE, $urandom_range(NCTR, NPIX - 1), $urandom,
				$urandom, $urandom, 0));
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
		for (int p = 0; p < n; p++) begin
			h = $urandom_range(0, 3);
			if ($urandom_range(0, 4) == 0)
				s = mk(kcq_pkg::CMD_LOAD_PIXEL, p, $urandom, $urandom, $urandom, p == n - 1);
			else
				s = mk(kcq_pkg::CMD_LOAD_PIXEL, p, near(hub[h]), near(hub[(h + 1) % 4]),
					near(hub[(h + 2) % 4]), p == n - 1);
			send_cmd(s);
			if ($urandom_range(0, 9) == 0)
				send_cmd(mk(kcq_pkg::CMD_READ_CENTRE, $urandom_range(0, 15), $urandom,
					$urandom, $urandom, 1));
		end
		if ($urandom_range(0, 4) == 0)
			send_cmd(mk(kcq_pkg::CMD_LOAD_PIXEL, $urandom_range(n, NPIX - 1), $urandom,
				$urandom, $urandom, 0));
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 1) == 0)
				send_cmd(mk(kcq_pkg::CMD_READ_PIXEL, $urandom_range(0, labelled_upto - 1),
					$urandom, $urandom, $urandom, $urandom_range(0, 1)));
			else
				send_cmd(mk(kcq_pkg::CMD_READ_CENTRE, $urandom_range(0, 15), $urandom,
					$urandom, $urandom, 0));
		end
	endtask

	initial begin
		int cfg_list [9][3];
		int goal;
		err_cnt = 0;
		transfers = 0;
		idle_on = 1;
		hold_req = 0;
		labelled_upto = 0;
		cfg_k = kcq_pkg::RST_NUM_CLUSTERS;
		cfg_color = 0;
		cfg_iter = kcq_pkg::RST_MAX_ITER;
		for (int j = 0; j < NCTR; j++)
			centres[j] = 24'h0;
		cfg_list = '{'{2, 0, 64}, '{8, 1, 255}, '{1, 0, 1}, '{0, 1, 0}, '{15, 0, 3},
			'{5, 1, 64}, '{3, 0, 255}, '{8, 0, 2}, '{4, 1, 1}};

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= kcq_pkg::REG_NUM_CLUSTERS;
		cfg_data <= 8'd0;
		in_ch.valid <= 1'b0;
		in_ch.command <= kcq_pkg::CMD_LOAD_PIXEL;
		in_ch.item_index <= 12'd0;
		in_ch.chan0 <= 8'd0;
		in_ch.chan1 <= 8'd0;
		in_ch.chan2 <= 8'd0;
		in_ch.last_pixel <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gray mode, reset configuration: two centres, a pass limit of 64.
		add_row(mkx(mk(kcq_pkg::CMD_READ_CENTRE, 0, 0, 0, 0, 0), kcq_pkg::KIND_CENTRE,
			0, 0, 0, 0));
		add_row(mkx(mk(kcq_pkg::CMD_READ_CENTRE, 7, 0, 0, 0, 0), kcq_pkg::KIND_CENTRE,
			7, 0, 0, 0));
		add_row(mk(kcq_pkg::CMD_READ_CENTRE, 8, 0, 0, 0, 0));
		add_row(mk(kcq_pkg::CMD_SET_CENTRE, 4095, 255, 255, 255, 0));
		add_row(mk(kcq_pkg::CMD_SET_CENTRE, 0, 10, 0, 0, 0));
		add_row(mk(kcq_pkg::CMD_SET_CENTRE, 1, 200, 255, 255, 0));
		add_row(mkx(mk(kcq_pkg::CMD_READ_CENTRE, 1, 0, 0, 0, 0), kcq_pkg::KIND_CENTRE,
			1, 200, 0, 0));
		add_row(mk(kcq_pkg::CMD_LOAD_PIXEL, 0, 0, 0, 0, 0));
		add_row(mk(kcq_pkg::CMD_LOAD_PIXEL, 1, 255, 0, 0, 0));
		add_row(mk(kcq_pkg::CMD_LOAD_PIXEL, 2, 20, 0, 0, 0));
		add_row(mkx(mk(kcq_pkg::CMD_LOAD_PIXEL, 3, 190, 255, 255, 1), kcq_pkg::KIND_DONE,
			0, 0, 2, 1));
		add_row(mkx(mk(kcq_pkg::CMD_READ_PIXEL, 1, 0, 0, 0, 0), kcq_pkg::KIND_PIXEL,
			1, 222, 0, 0));
		add_row(mkx(mk(kcq_pkg::CMD_READ_PIXEL, 0, 0, 0, 0, 0), kcq_pkg::KIND_PIXEL,
			0, 10, 0, 0));
		add_row(mk(kcq_pkg::CMD_SET_CENTRE, 2, 5, 0, 0, 1));
		add_row(mk(kcq_pkg::CMD_LOAD_PIXEL, 4095, 255, 255, 255, 0));
		add_row(mkx(mk(kcq_pkg::CMD_READ_CENTRE, 7, 0, 0, 0, 0), kcq_pkg::KIND_CENTRE,
			7, 0, 0, 0));
		// Two equal centres: the lower one wins the tie, the other goes empty.
		add_row(mk(kcq_pkg::CMD_SET_CENTRE, 0, 100, 0, 0, 0));
		add_row(mk(kcq_pkg::CMD_SET_CENTRE, 1, 100, 0, 0, 0));
		add_row(mkx(mk(kcq_pkg::CMD_LOAD_PIXEL, 0, 100, 0, 0, 1), kcq_pkg::KIND_DONE,
			0, 0, 2, 1));
		add_row(mkx(mk(kcq_pkg::CMD_READ_PIXEL, 0, 0, 0, 0, 0), kcq_pkg::KIND_PIXEL,
			0, 100, 0, 0));
		add_row(mkx(mk(kcq_pkg::CMD_READ_CENTRE, 1, 0, 0, 0, 0), kcq_pkg::KIND_CENTRE,
			1, 255, 0, 0));
		// Pixel 3 keeps its label from the older frame; its centre is now the empty value.
		add_row(mkx(mk(kcq_pkg::CMD_READ_PIXEL, 3, 0, 0, 0, 0), kcq_pkg::KIND_PIXEL,
			1, 255, 0, 0));
		add_row(mk(kcq_pkg::CMD_READ_PIXEL, 2, 0, 0, 0, 1));
		foreach (dir_tab[i])
			send_cmd(dir_tab[i]);

		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 8)
				idle_on = 0;
			if (ph > 0) begin
				wait_drained();
				set_config(cfg_list[ph][0], cfg_list[ph][1], cfg_list[ph][2]);
			end
			if (ph == 2) begin
				// The result side stops for a long time while reads keep coming.
				hold_req = 1;
				repeat (40)
					send_cmd(mk(kcq_pkg::CMD_READ_CENTRE, $urandom_range(0, 7), 0, 0, 0, 0));
			end
			goal = 25 + (ph + 1) * 55;
			while (transfers < goal)
				random_frame();
		end

		wait_drained();
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* files.f */
rtl/kcq_pkg.sv
rtl/kcq_in_if.sv
rtl/kcq_out_if.sv
rtl/kcq_iter_unit.sv
rtl/kmeans_color_quantizer_unit.sv
sim/tb_kmeans_color_quantizer_unit.sv
